// File: src/qdlb_pkg.sv
// shared types, constants and command structs for the distance lower bound unit
`timescale 1ns / 1ps

package qdlb_pkg;

  // field widths
  localparam int ELEM_W     = 15;
  localparam int LV_W       = 3;
  localparam int SUM_W      = 64;
  localparam int BOUND_W    = 48;
  localparam int CFG_W      = 32;
  localparam int REL_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int LANES_DEF  = 4;

  // output stream carries sum then bound, already a whole number of bytes
  localparam int OUT_TDATA_W = SUM_W + BOUND_W;

  // iterative units
  localparam int ROOT_W       = 48;
  localparam int REM_W        = ROOT_W + 3;
  localparam int ROOT_STEPS   = ROOT_W;
  localparam int DIST_W       = 80;
  localparam int CHUNK_W      = 16;
  localparam int ACC_W        = DIST_W + REL_W;
  localparam int SCALE_CHUNKS = ROOT_W / CHUNK_W;
  localparam int DIST_CHUNKS  = DIST_W / CHUNK_W;
  localparam int CNT_W        = $clog2(ROOT_STEPS);

  // register reset values
  localparam logic             WIDE_MODE_RST = 1'b0;
  localparam logic [CFG_W-1:0] SCALE_RST     = 32'h0001_0000;
  localparam logic [CFG_W-1:0] ERR_RST       = 32'h0000_0000;
  localparam logic [REL_W-1:0] REL_ONE       = 17'h1_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE_MODE  = 2'd0,
    CFG_SCALE      = 2'd1,
    CFG_QUANT_ERR  = 2'd2,
    CFG_RELAX      = 2'd3
  } cfg_idx_t;

  // controller states
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_MUL_LOAD,
    ST_MUL_SCALE,
    ST_SUB,
    ST_MUL_REL
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic in_take;
    logic root_load;
    logic root_step;
    logic mul_load;
    logic mul_step;
    logic mul_sel_rel;
    logic sub_load;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: src/qdlb_ctrl.sv
// sequencer for accumulation, square root, scaling and result hand-off
`timescale 1ns / 1ps

module qdlb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tlast,
  output logic           s_tready,
  input  qdlb_pkg::sts_t sts,
  output qdlb_pkg::cmd_t cmd
);
  import qdlb_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             finish, finish_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_ACCUM;
      cnt    <= '0;
      finish <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      finish <= finish_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    finish_next = finish;
    cmd         = '0;
    s_tready    = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        // finish flags a bound that waits for the output register
        if (finish) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            finish_next  = 1'b0;
          end
        end else begin
          s_tready    = 1'b1;
          cmd.in_take = s_tvalid;
          if (s_tvalid && s_tlast) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last item lands in the running sum this cycle
        state_next = ST_ROOT_LOAD;
      end
      ST_ROOT_LOAD: begin
        cmd.root_load = 1'b1;
        cnt_next      = CNT_W'(ROOT_STEPS - 1);
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = ST_MUL_LOAD;
        end
      end
      ST_MUL_LOAD: begin
        cmd.mul_load = 1'b1;
        cnt_next     = CNT_W'(SCALE_CHUNKS - 1);
        state_next   = ST_MUL_SCALE;
      end
      ST_MUL_SCALE: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        cmd.sub_load = 1'b1;
        cnt_next     = CNT_W'(DIST_CHUNKS - 1);
        state_next   = ST_MUL_REL;
      end
      ST_MUL_REL: begin
        cmd.mul_step    = 1'b1;
        cmd.mul_sel_rel = 1'b1;
        cnt_next        = cnt - 1'b1;
        if (cnt == '0) begin
          finish_next = 1'b1;
          state_next  = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

// File: src/qdlb_dp.sv
// datapath: lane squares, running sum, root unit, chunked multiplier, output register
`timescale 1ns / 1ps

module qdlb_dp #(
  parameter int LANES = qdlb_pkg::LANES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [((2*LANES*qdlb_pkg::ELEM_W + qdlb_pkg::LV_W + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qdlb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qdlb_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   m_tready,
  output logic                                   m_tvalid,
  output logic [qdlb_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  qdlb_pkg::cmd_t                         cmd,
  output qdlb_pkg::sts_t                         sts
);
  import qdlb_pkg::*;

  localparam int LV_LSB = 2 * LANES * ELEM_W;
  localparam int SQ_W   = 2 * ELEM_W;

  // configuration registers
  logic             wide_mode;
  logic [CFG_W-1:0] scale;
  logic [CFG_W-1:0] quant_err;
  logic [REL_W-1:0] relax_factor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode    <= WIDE_MODE_RST;
      scale        <= SCALE_RST;
      quant_err    <= ERR_RST;
      relax_factor <= REL_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDE_MODE:  wide_mode    <= cfg_data[0];
        CFG_SCALE:      scale        <= cfg_data;
        CFG_QUANT_ERR:  quant_err    <= cfg_data;
        CFG_RELAX:      relax_factor <= cfg_data[REL_W-1:0];
      endcase
    end
  end

  // stage 1: per-lane squared difference, zero for lanes beyond the count
  logic [LV_W-1:0] lanes_valid;
  logic [SQ_W-1:0] lane_sq [LANES];
  logic            s1_valid;

  assign lanes_valid = s_tdata[LV_LSB +: LV_W];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [ELEM_W-1:0] a, b, d;
    logic [SQ_W-1:0]   sq;
    logic              on;

    always_comb begin
      a = wide_mode ? s_tdata[i*ELEM_W +: ELEM_W]
                    : {7'b0, s_tdata[i*ELEM_W +: 8]};
      b = wide_mode ? s_tdata[(LANES+i)*ELEM_W +: ELEM_W]
                    : {7'b0, s_tdata[(LANES+i)*ELEM_W +: 8]};
      d  = (a >= b) ? a - b : b - a;
      sq = {{ELEM_W{1'b0}}, d} * {{ELEM_W{1'b0}}, d};
      on = (32'(lanes_valid) > i);
    end

    always_ff @(posedge clk) begin
      if (cmd.in_take) begin
        lane_sq[i] <= on ? sq : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.in_take;
    end
  end

  // stage 2: running sum, wraps at 64 bits
  logic [SUM_W-1:0] lane_total;
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] sum_hold;

  always_comb begin
    lane_total = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_total = lane_total + SUM_W'(lane_sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (cmd.root_load) begin
      running_sum <= '0;
    end else if (s1_valid) begin
      running_sum <= running_sum + lane_total;
    end
  end

  // digit-by-digit square root of sum * 2^32, one root bit per cycle
  logic [SUM_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem_sh, trial;

  assign rem_sh = {rem[REM_W-3:0], rad[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad      <= running_sum;
      sum_hold <= running_sum;
      rem      <= '0;
      root     <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // shared multiplier: 32 x 16 chunk per cycle, top chunk first
  logic [DIST_W-1:0]          shreg;
  logic [ACC_W-1:0]           acc;
  logic [REL_W-1:0]           rel;
  logic [CFG_W-1:0]           mul_a;
  logic [CFG_W+CHUNK_W-1:0]   prod;
  logic [DIST_W-1:0]          scaled;
  logic [DIST_W-1:0]          two_err;

  assign rel     = relax_factor[REL_W-1] ? REL_ONE : relax_factor;
  assign mul_a   = cmd.mul_sel_rel ? CFG_W'(rel) : scale;
  assign prod    = {{CHUNK_W{1'b0}}, mul_a} * {{CFG_W{1'b0}}, shreg[DIST_W-1 -: CHUNK_W]};
  assign scaled  = acc[DIST_W-1:0];
  assign two_err = DIST_W'({quant_err, 17'b0});

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      shreg <= {root, {(DIST_W-ROOT_W){1'b0}}};
      acc   <= '0;
    end else if (cmd.sub_load) begin
      // subtract twice the error radius, clamped at zero
      shreg <= (scaled < two_err) ? '0 : scaled - two_err;
      acc   <= '0;
    end else if (cmd.mul_step) begin
      shreg <= {shreg[DIST_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      acc   <= {acc[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(prod);
    end
  end

  // output register, freed on a transfer
  logic [SUM_W-1:0]   out_sum;
  logic [BOUND_W-1:0] out_bound;

  assign sts.out_free = !m_tvalid || m_tready;
  assign m_tdata      = {out_bound, out_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum   <= sum_hold;
      out_bound <= (|acc[ACC_W-1:DIST_W]) ? '1 : acc[DIST_W-1:32];
    end
  end

endmodule

// File: src/quantized_distance_lower_bound_unit.sv
// top level of the quantized distance lower bound unit
// throughput: one item per cycle while a vector pair accumulates (all lanes in one transfer)
// after a last item the sum drains, the bit-by-bit square root runs, then the 3 + 5 chunk
//   steps of the shared multiplier, before the bound goes to the output register
// input is held off during that work; the output register lets the next vector start
// reset (rst, synchronous): sum cleared, output empty, registers back to their defaults
`timescale 1ns / 1ps

module quantized_distance_lower_bound_unit #(
  parameter int LANES = qdlb_pkg::LANES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // a_lane0..a_lane(LANES-1), b_lane0..b_lane(LANES-1), lanes_valid, zero fill
  input  logic [((2*LANES*qdlb_pkg::ELEM_W + qdlb_pkg::LV_W + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic                                   s_tlast,
  // sum_sq, lower_bound
  output logic [qdlb_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qdlb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qdlb_pkg::CFG_W-1:0]             cfg_data
);
  import qdlb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  qdlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  qdlb_dp #(
    .LANES (LANES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: test/quantized_distance_lower_bound_unit_tb.sv
// testbench for the quantized distance lower bound unit: directed table, then random vectors
`timescale 1ns / 1ps

module quantized_distance_lower_bound_unit_tb;
  import qdlb_pkg::*;

  localparam int S_W        = ((2*LANES_DEF*ELEM_W + LV_W + 7) / 8) * 8;
  localparam int QUIET      = 80;    // a wait that outlasts the time from a last item to its result
  localparam int LONG_HOLD  = 400;
  localparam int RAND_ITEMS = 1230;
  localparam int PHASES     = 8;
  localparam logic [BOUND_W-1:0] BOUND_SAT = '1;

  typedef logic [LANES_DEF-1:0][ELEM_W-1:0] lanes_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [BOUND_W-1:0] bound;
  } dist_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    cfg_idx_t           idx;
    logic [CFG_W-1:0]   val;
    lanes_t             a;
    lanes_t             b;
    logic [LV_W-1:0]    lv;
    logic               last;
    logic               typed;
    dist_result_t       res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [S_W-1:0]         s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic                   s_tlast = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // predictor state: register copies and the running sum
  logic               pr_wide;
  logic [CFG_W-1:0]   pr_scale;
  logic [CFG_W-1:0]   pr_err;
  logic [REL_W-1:0]   pr_relax;
  logic [SUM_W-1:0]   pr_sum;

  dist_result_t results_due[$];
  stim_row_t    dir_tab[$];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int vectors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int stall_reqs = 0;
  int stall_seen = 0;
  int stall_left = 0;

  quantized_distance_lower_bound_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // fail-safe limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // floor(sqrt(s * 2^32)) bit by bit
  function automatic logic [47:0] root_q16(input logic [SUM_W-1:0] s);
    logic [127:0] target;
    logic [127:0] trial_sq;
    logic [47:0]  r;
    logic [47:0]  c;
    target = {32'd0, s, 32'd0};
    r = '0;
    for (int bi = 47; bi >= 0; bi--) begin
      c = r | (48'd1 << bi);
      trial_sq = {80'd0, c} * {80'd0, c};
      if (trial_sq <= target) r = c;
    end
    return r;
  endfunction

  // scale the root, take off twice the error radius, relax and saturate
  function automatic logic [BOUND_W-1:0] bound_of_sum(input logic [SUM_W-1:0] s);
    logic [79:0]      scaled;
    logic [79:0]      margin;
    logic [REL_W-1:0] rel;
    logic [96:0]      prod;
    scaled = {48'd0, pr_scale} * {32'd0, root_q16(s)};
    margin = {31'd0, pr_err, 17'd0};
    if (scaled < margin) return '0;
    scaled = scaled - margin;
    rel = (pr_relax > REL_ONE) ? REL_ONE : pr_relax;
    prod = {17'd0, scaled} * {80'd0, rel};
    if (prod[96:80] != '0) return BOUND_SAT;
    return prod[79:32];
  endfunction

  // fold one accepted item into the running sum; true when a result is due
  function automatic bit fold_item(input lanes_t a, input lanes_t b, input logic [LV_W-1:0] lv,
                                   input logic last, output dist_result_t res);
    int               n;
    logic [ELEM_W-1:0] ea;
    logic [ELEM_W-1:0] eb;
    logic [ELEM_W-1:0] d;
    n = (lv > LANES_DEF) ? LANES_DEF : lv;
    for (int i = 0; i < n; i++) begin
      ea = pr_wide ? a[i] : {7'd0, a[i][7:0]};
      eb = pr_wide ? b[i] : {7'd0, b[i][7:0]};
      d = (ea >= eb) ? ea - eb : eb - ea;
      pr_sum = pr_sum + {49'd0, d} * {49'd0, d};
    end
    res = '0;
    if (!last) return 1'b0;
    res.sum = pr_sum;
    res.bound = bound_of_sum(pr_sum);
    pr_sum = '0;
    return 1'b1;
  endfunction

  function automatic stim_row_t item_row(input lanes_t a, input lanes_t b,
                                         input logic [LV_W-1:0] lv, input logic last,
                                         input logic typed, input logic [SUM_W-1:0] sum,
                                         input logic [BOUND_W-1:0] bound);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.a = a;
    r.b = b;
    r.lv = lv;
    r.last = last;
    r.typed = typed;
    r.res.sum = sum;
    r.res.bound = bound;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ELEM_W'($urandom_range(0, 255));
      default: return ELEM_W'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [SUM_W-1:0] exp_v,
                               input logic [SUM_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, exp_v, act_v);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen <= stall_reqs;
      stall_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // check every result transfer against the oldest expectation
  always @(posedge clk) begin
    dist_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected result sum", '0, m_tdata[SUM_W-1:0]);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[SUM_W-1:0] !== want.sum)
          flag_mismatch("sum_sq", want.sum, m_tdata[SUM_W-1:0]);
        if (m_tdata[SUM_W +: BOUND_W] !== want.bound)
          flag_mismatch("lower_bound", {16'd0, want.bound}, {16'd0, m_tdata[SUM_W +: BOUND_W]});
      end
    end
  end

  // offer one item, wait for its transfer, then predict
  task automatic send_item(input lanes_t a, input lanes_t b, input logic [LV_W-1:0] lv,
                           input logic last, input logic typed, input dist_result_t typed_res);
    dist_result_t res;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= S_W'({lv, b, a});
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (fold_item(a, b, lv, last, res)) results_due.push_back(typed ? typed_res : res);
  endtask

  // drain everything, give the datapath time to settle, then write one register
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_WIDE_MODE:  pr_wide = val[0];
      CFG_SCALE:      pr_scale = val;
      CFG_QUANT_ERR:  pr_err = val;
      CFG_RELAX:      pr_relax = val[REL_W-1:0];
      default: ;
    endcase
  endtask

  // one vector pair of random length and content
  task automatic run_vector(inout int sent);
    int               len;
    lanes_t           a;
    lanes_t           b;
    logic [LV_W-1:0]  lv;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      for (int i = 0; i < LANES_DEF; i++) begin
        a[i] = rand_elem();
        b[i] = rand_elem();
      end
      lv = ($urandom_range(0, 3) == 0) ? LV_W'($urandom_range(0, 7)) : LV_W'(LANES_DEF);
      send_item(a, b, lv, k == len - 1, 1'b0, '0);
      sent++;
    end
    vectors++;
  endtask

  // pick register values, extremes included
  task automatic set_registers(input int ph);
    logic [CFG_W-1:0] v;
    write_reg(CFG_WIDE_MODE, (ph == 0) ? 32'd0 : 32'($urandom_range(0, 1)));
    case ($urandom_range(0, 4))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      2: v = SCALE_RST;
      default: v = $urandom();
    endcase
    write_reg(CFG_SCALE, (ph == 0) ? SCALE_RST : v);
    case ($urandom_range(0, 4))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      2: v = 32'($urandom_range(0, 65535));
      default: v = $urandom() >> $urandom_range(0, 16);
    endcase
    write_reg(CFG_QUANT_ERR, (ph == 0) ? ERR_RST : v);
    case ($urandom_range(0, 4))
      0: v = 32'd0;
      1: v = 32'h1_FFFF;
      2: v = {15'd0, REL_ONE};
      default: v = 32'($urandom_range(0, 65536));
    endcase
    write_reg(CFG_RELAX, (ph == 0) ? {15'd0, REL_ONE} : v);
  endtask

  initial begin
    int sent;
    int target;
    stim_row_t r;
    pr_wide = WIDE_MODE_RST;
    pr_scale = SCALE_RST;
    pr_err = ERR_RST;
    pr_relax = REL_ONE;
    pr_sum = '0;

    // directed table: reset defaults first, then writes to each register, extremes included
    dir_tab.push_back(item_row({4{15'd3}}, {4{15'd0}}, 3'd1, 1'b1, 1'b1, 64'd9, 48'd196608));
    dir_tab.push_back(item_row({4{15'h1234}}, {4{15'd0}}, 3'd0, 1'b1, 1'b1, 64'd0, 48'd0));
    dir_tab.push_back(item_row({4{15'h7FFF}}, {4{15'h7F00}}, 3'd4, 1'b0, 1'b0, '0, '0));
    dir_tab.push_back(item_row({4{15'd0}}, {4{15'h00FF}}, 3'd7, 1'b1, 1'b0, '0, '0));
    dir_tab.push_back(reg_row(CFG_WIDE_MODE, 32'd1));
    dir_tab.push_back(item_row({4{15'h7FFF}}, {4{15'd0}}, 3'd4, 1'b1, 1'b1,
                               64'd4294705156, 48'd4294836224));
    dir_tab.push_back(item_row({4{15'h2AAA}}, {4{15'h2AAA}}, 3'd4, 1'b1, 1'b1, 64'd0, 48'd0));
    dir_tab.push_back(item_row({15'd9, 15'd700, 15'h5555, 15'd1}, {15'd8000, 15'd3, 15'd0, 15'd6},
                               3'd2, 1'b0, 1'b0, '0, '0));
    dir_tab.push_back(item_row({15'd0, 15'd20000, 15'd17, 15'h4000}, {15'd1, 15'd2, 15'd30000, 15'd5},
                               3'd3, 1'b1, 1'b0, '0, '0));
    dir_tab.push_back(item_row({4{15'd0}}, {4{15'h2000}}, 3'd5, 1'b0, 1'b0, '0, '0));
    dir_tab.push_back(item_row({4{15'h1111}}, {4{15'd7}}, 3'd6, 1'b1, 1'b0, '0, '0));
    dir_tab.push_back(reg_row(CFG_SCALE, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row({4{15'h7FFF}}, {4{15'd0}}, 3'd4, 1'b0, 1'b0, '0, '0));
    dir_tab.push_back(item_row({4{15'h7FFF}}, {4{15'd0}}, 3'd4, 1'b1, 1'b1,
                               64'd8589410312, BOUND_SAT));
    dir_tab.push_back(reg_row(CFG_SCALE, 32'd0));
    dir_tab.push_back(item_row({4{15'd100}}, {4{15'd0}}, 3'd1, 1'b1, 1'b1, 64'd10000, 48'd0));
    dir_tab.push_back(reg_row(CFG_SCALE, SCALE_RST));
    dir_tab.push_back(reg_row(CFG_QUANT_ERR, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row({4{15'h7FFF}}, {4{15'd0}}, 3'd1, 1'b1, 1'b1, 64'd1073676289, 48'd0));
    dir_tab.push_back(reg_row(CFG_QUANT_ERR, 32'h0001_0000));
    dir_tab.push_back(item_row({4{15'd5}}, {4{15'd0}}, 3'd1, 1'b1, 1'b1, 64'd25, 48'd196608));
    dir_tab.push_back(reg_row(CFG_RELAX, 32'd0));
    dir_tab.push_back(item_row({4{15'd7}}, {4{15'd0}}, 3'd1, 1'b1, 1'b1, 64'd49, 48'd0));
    dir_tab.push_back(reg_row(CFG_RELAX, 32'h1_FFFF));
    dir_tab.push_back(item_row({4{15'd0}}, {4{15'd9}}, 3'd1, 1'b1, 1'b1, 64'd81, 48'd458752));
    dir_tab.push_back(reg_row(CFG_RELAX, 32'd32768));
    dir_tab.push_back(item_row({4{15'd11}}, {4{15'd0}}, 3'd1, 1'b1, 1'b1, 64'd121, 48'd294912));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[n]) begin
      r = dir_tab[n];
      if (r.kind == ROW_REG) write_reg(r.idx, r.val);
      else send_item(r.a, r.b, r.lv, r.last, r.typed, r.res);
    end

    // random vectors across the idling phases and register settings
    sent = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_registers(ph);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      // hold the output off while items keep coming
      if (ph == 4) stall_reqs <= stall_reqs + 1;
      target = (RAND_ITEMS * (ph + 1)) / PHASES;
      while (sent < target) begin
        run_vector(sent);
        // let the block run dry after each vector in phase 5 that ends 51 to 60 items short of the target
        if (ph == 5 && sent >= target - 60 && sent < target - 50) begin
          s_tvalid <= 1'b0;
          while (results_due.size() != 0) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);

    $display("covered %0d items in %0d random vectors plus the directed table, %0d results",
             items_sent, vectors, results_seen);
    $display("%0d register writes over %0d phases of idling and stalling, %0d mismatches",
             reg_writes, PHASES, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/qdlb_pkg.sv
src/qdlb_ctrl.sv
src/qdlb_dp.sv
src/quantized_distance_lower_bound_unit.sv
test/quantized_distance_lower_bound_unit_tb.sv
